// ----- hw/rtl/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner package
// Operation codes, field widths and the transaction record that moves down
// the row of signature cells.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int SIG_W  = 4;   // width of a signature slot number
    localparam int POS_W  = 5;   // width of an element position
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_SCAN  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // One transaction as it travels through the cells. The hit fields are
    // filled in by the first cell that completes, so lower slots win.
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [SIG_W-1:0]  sig_index;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic              wild;
        logic              is_final;
        logic              is_last;
        logic              inject;
        logic              anchored;
        logic              hit;
        logic [SIG_W-1:0]  hit_sig;
        logic              ahit;
        logic [SIG_W-1:0]  ahit_sig;
    } wss_tok_t;

endpackage

// ----- hw/rtl/wildcard_signature_scanner.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner
// Shift-and matching of a byte stream against up to NUM_SIGS wildcard
// signatures, built as a row of signature cells and a result stage.
// ----------------------------------------------------------------------------
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   input    | in_valid / in_stall | op, sig_index, element_pos, element_byte,
//            |                     | element_wild, element_final, data_byte,
//            |                     | last_byte
//   output   | out_valid/out_stall | found, matched_sig
//   config   | cfg_valid/cfg_ready | cfg_data (anchored mode)
//
// One transaction enters per clock unless the input is stalled. Each one walks
// the cell row one cell a cycle while nothing stalls, then its result is registered.
// Cells apply writes, starts and bytes in arrival order, which keeps the
// per-slot state consistent; the lowest completing slot is picked on the way.
// Reset disables all slots and clears progress; element storage is not reset.
// The input is stalled only while a result is due and the output register
// still holds a result that the sink has not taken.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner
    import wss_pkg::*;
#(
    parameter int NUM_SIGS    = 16,
    parameter int MAX_SIG_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [SIG_W-1:0]  sig_index,
    input  logic [POS_W-1:0]  element_pos,
    input  logic [BYTE_W-1:0] element_byte,
    input  logic              element_wild,
    input  logic              element_final,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [SIG_W-1:0]  matched_sig,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic     mode_reg;
    logic     at_first_reg;
    logic     advance;
    logic     in_take;
    wss_tok_t entry_tok;
    wss_tok_t chain [NUM_SIGS];

    assign cfg_ready = 1'b1;
    assign in_stall  = !advance;
    assign in_take   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            at_first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (in_take)
            begin
                if (op_t'(op) == OP_START)
                begin
                    at_first_reg <= 1'b1;
                end
                else if (op_t'(op) == OP_SCAN)
                begin
                    at_first_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        entry_tok           = '0;
        entry_tok.valid     = in_valid;
        entry_tok.op        = op_t'(op);
        entry_tok.sig_index = sig_index;
        entry_tok.pos       = element_pos;
        entry_tok.data      = (op_t'(op) == OP_WRITE) ? element_byte : data_byte;
        entry_tok.wild      = element_wild;
        entry_tok.is_final  = element_final;
        entry_tok.is_last   = last_byte;
        entry_tok.inject    = !mode_reg || at_first_reg;
        entry_tok.anchored  = mode_reg;
    end

    for (genvar k = 0; k < NUM_SIGS; k++)
    begin : g_cell
        wss_tok_t cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = entry_tok;
        end
        else
        begin : g_body
            assign cell_in = chain[k-1];
        end

        wss_cell #(
            .MAX_SIG_LEN (MAX_SIG_LEN),
            .CELL_IDX    (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (cell_in),
            .tok_out (chain[k])
        );
    end

    wss_report u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok         (chain[NUM_SIGS-1]),
        .out_stall   (out_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .found       (found),
        .matched_sig (matched_sig)
    );

endmodule

// ----- hw/rtl/wss_cell.sv -----
// ----------------------------------------------------------------------------
// Signature cell
// Holds one signature (elements, length, enable), its shift-and progress
// vector and its anchored hit flag. Updates them from the transaction at its
// input and passes the transaction on to the next cell through a register.
// ----------------------------------------------------------------------------
module wss_cell
    import wss_pkg::*;
#(
    parameter int MAX_SIG_LEN = 32,
    parameter int CELL_IDX    = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  wss_tok_t tok_in,
    output wss_tok_t tok_out
);

    localparam int LPOS_W = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    // Only slots that the slot number field can address are ever loaded.
    localparam bit REACHABLE = (CELL_IDX < (1 << SIG_W));

    typedef logic [MAX_SIG_LEN-1:0] vec_t;

    logic [BYTE_W:0]   elem_reg [MAX_SIG_LEN];
    logic [LPOS_W-1:0] final_pos_reg;
    logic              enabled_reg;
    vec_t              prog_reg;
    logic              ahit_reg;
    wss_tok_t          tok_reg;
    wss_tok_t          tok_next;

    vec_t              accept;
    vec_t              step;
    logic              complete;
    logic              ahit_next;
    logic              sel;
    logic              do_write;
    logic [LPOS_W-1:0] wr_pos;

    always_comb
    begin
        for (int k = 0; k < MAX_SIG_LEN; k++)
        begin
            accept[k] = (elem_reg[k][BYTE_W] || (elem_reg[k][BYTE_W-1:0] == tok_in.data))
                        && (k <= int'(final_pos_reg));
        end
        step      = ((prog_reg << 1) | vec_t'(tok_in.inject)) & accept;
        complete  = enabled_reg && step[final_pos_reg];
        sel       = tok_in.valid && advance;
        wr_pos    = LPOS_W'(tok_in.pos);
        do_write  = REACHABLE && (tok_in.op == OP_WRITE)
                    && (tok_in.sig_index == SIG_W'(CELL_IDX))
                    && (int'(tok_in.pos) < MAX_SIG_LEN);
        ahit_next = ahit_reg || ((tok_in.op == OP_SCAN) && complete && tok_in.anchored);

        tok_next = tok_in;
        if (tok_in.op == OP_SCAN)
        begin
            if (complete && !tok_in.anchored && !tok_in.hit)
            begin
                tok_next.hit     = 1'b1;
                tok_next.hit_sig = SIG_W'(CELL_IDX);
            end
            if (ahit_next && !tok_in.ahit)
            begin
                tok_next.ahit     = 1'b1;
                tok_next.ahit_sig = SIG_W'(CELL_IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            prog_reg    <= '0;
            ahit_reg    <= 1'b0;
        end
        else if (sel)
        begin
            case (tok_in.op)
                OP_WRITE:
                begin
                    if (do_write && tok_in.is_final)
                    begin
                        enabled_reg <= 1'b1;
                        prog_reg    <= '0;
                    end
                end
                OP_START:
                begin
                    prog_reg <= '0;
                    ahit_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (enabled_reg)
                    begin
                        prog_reg <= step;
                        ahit_reg <= ahit_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Element storage and length hold no reset; they are loaded before use.
    always_ff @(posedge clk)
    begin
        if (sel && do_write)
        begin
            elem_reg[wr_pos] <= {tok_in.wild, tok_in.data};
            if (tok_in.is_final)
            begin
                final_pos_reg <= wr_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hw/rtl/wss_report.sv -----
// ----------------------------------------------------------------------------
// Scan result stage
// Takes transactions from the end of the cell row, keeps the halt flag and
// holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module wss_report
    import wss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  wss_tok_t         tok,
    input  logic             out_stall,
    output logic             advance,
    output logic             out_valid,
    output logic             found,
    output logic [SIG_W-1:0] matched_sig
);

    logic             halted_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic [SIG_W-1:0] matched_reg;
    logic             pending;
    logic             res_found;
    logic [SIG_W-1:0] res_sig;

    always_comb
    begin
        pending = tok.valid && (tok.op == OP_SCAN) && !halted_reg
                  && (tok.anchored ? tok.is_last : (tok.hit || tok.is_last));
        // The row only freezes when a result must be written and the
        // register still holds one that the sink refuses.
        advance   = !(pending && out_valid_reg && out_stall);
        res_found = tok.anchored ? tok.ahit : tok.hit;
        if (!res_found)
        begin
            res_sig = '0;
        end
        else if (tok.anchored)
        begin
            res_sig = tok.ahit_sig;
        end
        else
        begin
            res_sig = tok.hit_sig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && tok.valid)
            begin
                if (tok.op == OP_START)
                begin
                    halted_reg <= 1'b0;
                end
                else if (pending)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (advance && pending)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pending)
        begin
            found_reg   <= res_found;
            matched_reg <= res_sig;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign matched_sig = matched_reg;

endmodule

// ----- hw/rtl/wss_checker.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner port checker
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module wss_checker
    import wss_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             found,
    input logic [SIG_W-1:0] matched_sig,
    input logic             cfg_ready
);

    // A miss reports slot zero.
    a_miss_slot_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> matched_sig == '0)
        else $error("miss transaction carries a nonzero slot");

    // A held result keeps its payload.
    a_result_holds : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(matched_sig))
        else $error("stalled result changed or vanished");

    // The input only backs up behind a refused result.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    a_cfg_always_ready : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind wildcard_signature_scanner wss_checker u_wss_checker (.*);

// ----- sim/wildcard_signature_scanner_checker.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner checker
// Watches the input, output and configuration channels of the scanner and
// keeps its own copy of the signature table, the shift-and progress vectors
// and the scan flags. Every accepted input transaction is run through that
// copy. A transaction that ends a match or a stream queues the verdict it
// should produce. Each accepted output transaction is compared with the
// oldest queued verdict.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner_checker
    import wss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        op,
    input  logic [SIG_W-1:0]  sig_index,
    input  logic [POS_W-1:0]  element_pos,
    input  logic [BYTE_W-1:0] element_byte,
    input  logic              element_wild,
    input  logic              element_final,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              found,
    input  logic [SIG_W-1:0]  matched_sig,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    output int                fail_count,
    output int                pending,
    output int                hit_total,
    output int                miss_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int DEPTH = 32;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic             found;
        logic [SIG_W-1:0] sig;
    } scan_verdict_t;

    logic [8:0]       pattern_mem [SLOTS][DEPTH];
    logic [5:0]       slot_len [SLOTS];
    logic [SLOTS-1:0] slot_on;
    logic [DEPTH-1:0] track_vec [SLOTS];
    logic [SLOTS-1:0] prefix_done;
    logic             at_start;
    logic             halted;
    logic             anchored;

    scan_verdict_t due_verdicts[$];
    scan_verdict_t want;
    int            errors = 0;
    int            hits = 0;
    int            misses = 0;

    // Applies one transaction to the shadow state; returns 1 when it produces
    // a verdict.
    function automatic logic scan_step(input op_t kind, input logic [SIG_W-1:0] slot,
                                       input logic [POS_W-1:0] pos,
                                       input logic [BYTE_W-1:0] eb, input logic wild,
                                       input logic fin, input logic [BYTE_W-1:0] db,
                                       input logic last, output scan_verdict_t verdict);
        logic [DEPTH-1:0] accept;
        logic [DEPTH-1:0] nxt;
        logic             inject;
        logic             hit;
        logic [SIG_W-1:0] hit_sig;
        logic             produced;
        verdict  = '0;
        produced = 1'b0;
        hit      = 1'b0;
        hit_sig  = '0;
        case (kind)
            OP_WRITE:
            begin
                pattern_mem[slot][pos] = {wild, eb};
                if (fin)
                begin
                    slot_len[slot]  = 6'(pos) + 6'd1;
                    slot_on[slot]   = 1'b1;
                    track_vec[slot] = '0;
                end
            end
            OP_START:
            begin
                for (int i = 0; i < SLOTS; i++)
                    track_vec[i] = '0;
                prefix_done = '0;
                at_start    = 1'b1;
                halted      = 1'b0;
            end
            OP_SCAN:
            begin
                if (!halted)
                begin
                    // In anchored mode a new start offset opens only on the first byte.
                    inject = !anchored || at_start;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_on[i])
                        begin
                            accept = '0;
                            for (int k = 0; k < int'(slot_len[i]); k++)
                                if (pattern_mem[i][k][8] || pattern_mem[i][k][7:0] == db)
                                    accept[k] = 1'b1;
                            nxt = {track_vec[i][DEPTH-2:0], inject} & accept;
                            track_vec[i] = nxt;
                            if (nxt[slot_len[i] - 6'd1])
                            begin
                                if (anchored)
                                    prefix_done[i] = 1'b1;
                                else if (!hit)
                                begin
                                    hit     = 1'b1;
                                    hit_sig = SIG_W'(i);
                                end
                            end
                        end
                    end
                    at_start = 1'b0;
                    if (anchored && last)
                    begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (prefix_done[i])
                            begin
                                hit     = 1'b1;
                                hit_sig = SIG_W'(i);
                            end
                    end
                    if (hit && (!anchored || last))
                    begin
                        verdict  = '{found: 1'b1, sig: hit_sig};
                        produced = 1'b1;
                    end
                    else if (last)
                        produced = 1'b1;
                    if (produced)
                        halted = 1'b1;
                end
            end
            default: ;
        endcase
        return produced;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            slot_on     = '0;
            prefix_done = '0;
            at_start    = 1'b1;
            halted      = 1'b0;
            anchored    = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                track_vec[i] = '0;
            due_verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                anchored = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (due_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOWN_MISMATCHES)
                        $display("%0t: unexpected result found=%0d matched_sig=%0d",
                                 $time, found, matched_sig);
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (want.found)
                        hits++;
                    else
                        misses++;
                    if (found !== want.found || matched_sig !== want.sig)
                    begin
                        errors++;
                        if (errors <= SHOWN_MISMATCHES)
                            $display("%0t: expected found=%0d sig=%0d, got found=%0d sig=%0d",
                                     $time, want.found, want.sig, found, matched_sig);
                    end
                end
            end
            if (in_valid && !in_stall)
                if (scan_step(op_t'(op), sig_index, element_pos, element_byte, element_wild,
                              element_final, data_byte, last_byte, want))
                    due_verdicts = {due_verdicts, want};
        end
        fail_count <= errors;
        pending    <= due_verdicts.size();
        hit_total  <= hits;
        miss_total <= misses;
    end

endmodule

// ----- sim/wildcard_signature_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// Wildcard signature scanner testbench
// Loads signatures with fixed bytes and wildcards, then scans byte streams in
// free and anchored mode. A short directed sequence comes first, then random
// streams that mostly embed loaded signatures, mixed with stray transactions.
// Both channels idle at random. A separate checker predicts every verdict.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner_tb
    import wss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL      = 1400;
    localparam int SETTLE         = 40;    // pipeline is NUM_SIGS + 1 deep
    localparam int WATCHDOG_LIMIT = 4000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        op = '0;
    logic [SIG_W-1:0]  sig_index = '0;
    logic [POS_W-1:0]  element_pos = '0;
    logic [BYTE_W-1:0] element_byte = '0;
    logic              element_wild = 1'b0;
    logic              element_final = 1'b0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              found;
    logic [SIG_W-1:0]  matched_sig;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;

    int fail_count;
    int pending;
    int hit_total;
    int miss_total;

    // What the stimulus knows about the loaded table, used to build streams.
    logic [8:0]  shadow_pat [16][32];
    logic [5:0]  shadow_len [16];
    logic [15:0] shadow_on = '0;
    logic [31:0] shadow_written [16];

    logic mode_now = 1'b0;
    logic calm = 1'b0;
    logic keep_open = 1'b0;
    int   n_writes = 0;
    int   n_starts = 0;
    int   n_bytes = 0;
    int   n_nops = 0;
    int   n_phases = 0;
    int   work_items = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    wildcard_signature_scanner uut (.*);

    wildcard_signature_scanner_checker checker_inst (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Output stall in bursts: mostly short, now and then long.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (calm || $urandom_range(0, 9) < 6)
        begin
            out_stall  <= 1'b0;
            stall_left <= calm ? 0 : int'($urandom_range(0, 7));
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 50))
                                                      : int'($urandom_range(0, 2));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Small alphabet so that partial matches happen often.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 8'h41 + 8'($urandom_range(0, 3));
        if (r == 6)
            return 8'h00;
        if (r == 7)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 16);
        return $urandom_range(17, 32);
    endfunction

    task automatic send_item(input op_t kind, input logic [3:0] s, input logic [4:0] p,
                             input logic [7:0] eb, input logic w, input logic f,
                             input logic [7:0] db, input logic lb);
        int gap;
        in_valid      <= 1'b1;
        op            <= kind;
        sig_index     <= s;
        element_pos   <= p;
        element_byte  <= eb;
        element_wild  <= w;
        element_final <= f;
        data_byte     <= db;
        last_byte     <= lb;
        do
            @(posedge clk);
        while (in_stall);
        case (kind)
            OP_WRITE: n_writes++;
            OP_START: n_starts++;
            OP_SCAN:  n_bytes++;
            default:  n_nops++;
        endcase
        if (kind != OP_NONE)
            work_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_element(input logic [3:0] s, input logic [4:0] p, input logic [7:0] b,
                                 input logic w, input logic f);
        shadow_pat[s][p]     = {w, b};
        shadow_written[s][p] = 1'b1;
        if (f)
        begin
            shadow_len[s] = 6'(p) + 6'd1;
            shadow_on[s]  = 1'b1;
        end
        send_item(OP_WRITE, s, p, b, w, f, 8'($urandom), 1'($urandom));
    endtask

    task automatic write_random_element(input logic [3:0] s, input logic [4:0] p,
                                        input logic f);
        if ($urandom_range(0, 4) == 0)
            write_element(s, p, 8'($urandom), 1'b1, f);
        else
            write_element(s, p, pick_byte(), 1'b0, f);
    endtask

    // Every element below the length is written before the final one.
    task automatic load_signature(input int s, input int len);
        logic desc;
        desc = 1'($urandom);
        for (int i = 0; i < len - 1; i++)
            write_random_element(4'(s), 5'(desc ? len - 2 - i : i), 1'b0);
        write_random_element(4'(s), 5'(len - 1), 1'b1);
    endtask

    task automatic start_scan();
        send_item(OP_START, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic lb);
        send_item(OP_SCAN, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), b, lb);
    endtask

    task automatic embed_signature(ref logic [7:0] bytes[$]);
        int s;
        do
            s = $urandom_range(0, 15);
        while (!shadow_on[s]);
        for (int k = 0; k < int'(shadow_len[s]); k++)
            bytes = {bytes, (shadow_pat[s][k][8] ? pick_byte() : shadow_pat[s][k][7:0])};
    endtask

    task automatic run_stream(input int min_len);
        logic [7:0] bytes[$];
        if (shadow_on != 0 && (mode_now || $urandom_range(0, 2) == 0))
            embed_signature(bytes);
        while (bytes.size() < min_len)
        begin
            if (shadow_on != 0 && $urandom_range(0, 3) == 0)
                embed_signature(bytes);
            else
                bytes = {bytes, pick_byte()};
        end
        foreach (bytes[i])
            scan_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic noise_item();
        int          s;
        int          p;
        logic [31:0] lower;
        case ($urandom_range(0, 5))
            0: send_item(OP_NONE, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom), 8'($urandom), 1'($urandom));
            1: write_random_element(4'($urandom), 5'($urandom), 1'b0);
            2:
            begin
                // A final element is only written once everything below it is loaded.
                s = $urandom_range(0, 15);
                p = $urandom_range(0, 31);
                lower = (p == 0) ? 32'd0 : ((32'd1 << p) - 32'd1);
                write_random_element(4'(s), 5'(p), (shadow_written[s] & lower) == lower);
            end
            3: scan_byte(8'($urandom), $urandom_range(0, 3) == 0);
            4: start_scan();
            default:
            begin
                // Rewriting the final element of a live slot resets its progress.
                if (shadow_on != 0)
                begin
                    do
                        s = $urandom_range(0, 15);
                    while (!shadow_on[s]);
                    write_random_element(4'(s), 5'(shadow_len[s] - 6'd1), 1'b1);
                end
            end
        endcase
    endtask

    task automatic drain_results(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        drain_results(SETTLE);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_now = m;
        n_phases++;
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
            shadow_written[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single byte signature, leading wildcard, inner wildcard.
        write_element(4'd0, 5'd0, 8'hFF, 1'b0, 1'b1);
        write_element(4'd15, 5'd0, 8'h00, 1'b1, 1'b0);
        write_element(4'd15, 5'd1, 8'h00, 1'b0, 1'b1);
        write_element(4'd3, 5'd0, 8'h41, 1'b0, 1'b0);
        write_element(4'd3, 5'd1, 8'hAA, 1'b1, 1'b0);
        write_element(4'd3, 5'd2, 8'h43, 1'b0, 1'b1);
        send_item(OP_NONE, 4'hF, 5'h1F, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
        start_scan();
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h41, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b1);     // lands after the hit, so it is dropped
        start_scan();
        scan_byte(8'h41, 1'b0);
        scan_byte(8'h7E, 1'b0);
        scan_byte(8'h43, 1'b0);
        start_scan();
        scan_byte(8'h12, 1'b0);
        scan_byte(8'h34, 1'b1);
        start_scan();
        scan_byte(8'hFF, 1'b0);
        start_scan();
        scan_byte(8'h55, 1'b0);
        write_element(4'd15, 5'd1, 8'h00, 1'b0, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h00, 1'b1);

        while (work_items < ITEM_GOAL)
        begin
            set_mode((n_phases < 2) ? 1'(n_phases) : 1'($urandom));
            calm <= (n_phases > 2 && $urandom_range(0, 3) == 0);
            if (n_phases == 1)
                load_signature($urandom_range(0, 15), 32);
            repeat ($urandom_range(2, 5))
            begin
                if (shadow_on == 0 || $urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 2))
                        load_signature($urandom_range(0, 15), pick_length());
                if (keep_open)
                    keep_open = 1'b0;
                else if ($urandom_range(0, 5) != 0)
                    start_scan();
                run_stream(($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                       : $urandom_range(3, 16));
                repeat ($urandom_range(0, 2))
                    noise_item();
                if ($urandom_range(0, 7) == 0)
                    drain_results(0);
            end
            // Leave a scan open so that the next mode applies to it mid-stream.
            if ($urandom_range(0, 1) == 0)
            begin
                start_scan();
                repeat ($urandom_range(1, 3))
                    scan_byte(pick_byte(), 1'b0);
                keep_open = 1'b1;
            end
        end

        drain_results(SETTLE);
        $display("Covered %0d writes, %0d starts, %0d bytes, %0d no-ops in %0d mode phases.",
                 n_writes, n_starts, n_bytes, n_nops, n_phases);
        $display("Verdicts compared: %0d signature hits, %0d streams without a match.",
                 hit_total, miss_total);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
